// ===== hdl/md5_pkg.sv =====
package md5_pkg;

  localparam int unsigned BLK_WORDS = 16;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last_word;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_result;
  } md5_out_t;

  // the four 32-bit words a, b, c, d of a chaining value or working set
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  // write port of the block buffer
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } md5_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_OUT
  } md5_state_t;

  localparam md5_abcd_t CHAIN_INIT = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {quarter, round mod 4}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0: idx = lo;
      2'd1: idx = (lo << 2) + lo + 4'd1;
      2'd2: idx = (lo << 1) + lo + 4'd5;
      2'd3: idx = (lo << 3) - lo;
      default: idx = lo;
    endcase
    return idx;
  endfunction

endpackage

// ===== hdl/md5_blk_buf.sv =====
module md5_blk_buf
  import md5_pkg::*;
(
  input  logic        clk,
  input  md5_wr_t     wr,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [BLK_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/md5_round.sv =====
module md5_round
  import md5_pkg::*;
(
  input  md5_abcd_t   cur,
  input  logic [5:0]  rnd,
  input  logic [31:0] km,
  output md5_abcd_t   nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  s;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1: f = (cur.d & cur.b) | (~cur.d & cur.c);
      2'd2: f = cur.b ^ cur.c ^ cur.d;
      2'd3: f = cur.c ^ (cur.b | ~cur.d);
      default: f = '0;
    endcase
    // km already holds round constant plus message word
    sum = f + cur.a + km;
    s   = ROT_S[{rnd[5:4], rnd[1:0]}];
    // rotate amount is never zero
    rot = (sum << s) | (sum >> (6'd32 - 6'(s)));
    nxt.a = cur.d;
    nxt.b = cur.b + rot;
    nxt.c = cur.b;
    nxt.d = cur.c;
  end

endmodule

// ===== hdl/md5_digest_engine.sv =====
// md5 digest engine
//
// msg channel (msg_valid/msg_ready/msg_data): one transaction per 32-bit
// message word, first byte in bits 7:0. the word flagged last_word closes
// the message and carries the count of valid bytes (0..4, larger reads as 4).
// dig channel (dig_valid/dig_ready/dig_data): four transactions per message,
// digest words a, b, c, d with word_index 0..3, last_result on d.
//
// timing: a body word that does not fill the block leaves the engine idle
// and ready for the next word. the sixteenth word of a block starts a
// compression (fetch of the first message word and round constant, 64
// rounds at one round per cycle through the shared round unit, fold into
// the chaining value). the last word is followed by padding, one or two
// compressions and the hand-out of the four digest words. msg_ready is
// high only while the engine is idle. the digest is held in an output
// register: a stalled receiver holds off the rest of the digest, and the
// next message may start while the final digest word still waits.
// reset (rst, synchronous) restores the initial chaining value, clears the
// length and word counters and drops dig_valid. the block buffer is not
// cleared: every word is written before it is read.
module md5_digest_engine
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     msg_valid,
  output logic     msg_ready,
  input  md5_in_t  msg_data,
  output logic     dig_valid,
  input  logic     dig_ready,
  output md5_out_t dig_data
);

  // compression step counter milestones
  localparam logic [6:0] STEP_FOLD = 7'd66;
  localparam logic [6:0] KM_FIRST  = 7'd1;
  localparam logic [6:0] KM_LAST   = 7'd64;
  localparam logic [6:0] RND_FIRST = 7'd2;
  localparam logic [6:0] RND_LAST  = 7'd65;

  md5_state_t state;
  md5_state_t state_next;
  md5_state_t ret;         // where to go after the compression
  md5_state_t ret_sel;

  logic [3:0]  wc;          // words now in the block buffer
  logic [63:0] bit_length;
  logic        pend_pad;    // pad word still owed after a full last word
  logic        len_lo_done; // low length word written, high word next
  logic [6:0]  step;
  logic [1:0]  out_idx;

  md5_abcd_t   chain;
  md5_abcd_t   work;
  md5_abcd_t   work_rnd;
  logic [31:0] km;
  logic [31:0] rd_data;
  logic [5:0]  rnd;
  logic [5:0]  kidx;

  md5_wr_t     wr;
  logic [31:0] push_word;
  logic [31:0] last_word_val;
  logic [2:0]  nbytes;
  logic        msg_fire;
  logic        out_load;
  logic [31:0] out_word;

  assign msg_ready = (state == S_IDLE);
  assign msg_fire  = msg_valid && msg_ready;
  assign out_load  = (state == S_OUT) && (!dig_valid || dig_ready);
  assign rnd       = 6'(step - RND_FIRST);
  assign kidx      = 6'(step - KM_FIRST);

  md5_blk_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (msg_index(step[5:0])),
    .rd_data (rd_data)
  );

  md5_round u_round (
    .cur (work),
    .rnd (rnd),
    .km  (km),
    .nxt (work_rnd)
  );

  // last word: keep the valid bytes, pad byte behind them if not full
  always_comb begin
    unique case (msg_data.bytes_valid) inside
      3'd0: begin
        last_word_val = {24'd0, PAD_BYTE};
        nbytes        = 3'd0;
      end
      3'd1: begin
        last_word_val = {16'd0, PAD_BYTE, msg_data.data_word[7:0]};
        nbytes        = 3'd1;
      end
      3'd2: begin
        last_word_val = {8'd0, PAD_BYTE, msg_data.data_word[15:0]};
        nbytes        = 3'd2;
      end
      3'd3: begin
        last_word_val = {PAD_BYTE, msg_data.data_word[23:0]};
        nbytes        = 3'd3;
      end
      [3'd4:3'd7]: begin
        last_word_val = msg_data.data_word;
        nbytes        = 3'd4;
      end
      default: begin
        last_word_val = msg_data.data_word;
        nbytes        = 3'd4;
      end
    endcase
  end

  // idle: message word; padding: pad word if owed, zeros to word 14, length
  always_comb begin
    if (state == S_IDLE) begin
      push_word = msg_data.last_word ? last_word_val : msg_data.data_word;
    end else if (pend_pad) begin
      push_word = {24'd0, PAD_BYTE};
    end else if (len_lo_done) begin
      push_word = bit_length[63:32];
    end else if (wc == 4'd14) begin
      push_word = bit_length[31:0];
    end else begin
      push_word = '0;
    end
    wr.en   = msg_fire || (state == S_PAD);
    wr.addr = wc;
    wr.data = push_word;
  end

  always_comb begin
    unique case (out_idx)
      2'd0: out_word = chain.a;
      2'd1: out_word = chain.b;
      2'd2: out_word = chain.c;
      2'd3: out_word = chain.d;
      default: out_word = chain.a;
    endcase
  end

  // next state and return target
  always_comb begin
    state_next = state;
    ret_sel    = S_IDLE;
    unique case (state)
      S_IDLE: begin
        ret_sel = msg_data.last_word ? S_PAD : S_IDLE;
        if (msg_fire) begin
          if (wc == 4'd15) begin
            state_next = S_COMP;
          end else if (msg_data.last_word) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        ret_sel = len_lo_done ? S_OUT : S_PAD;
        if (wc == 4'd15) begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        if (step == STEP_FOLD) begin
          state_next = ret;
        end
      end
      S_OUT: begin
        if (out_load && out_idx == 2'd3) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      ret         <= S_IDLE;
      wc          <= '0;
      bit_length  <= '0;
      pend_pad    <= 1'b0;
      len_lo_done <= 1'b0;
      step        <= '0;
      out_idx     <= '0;
      dig_valid   <= 1'b0;
      chain       <= CHAIN_INIT;
    end else begin
      if (wr.en) begin
        wc <= wc + 4'd1;
        if (wc == 4'd15) begin
          ret  <= ret_sel;
          step <= '0;
        end
      end

      if (msg_fire) begin
        if (msg_data.last_word) begin
          bit_length <= bit_length + {58'd0, nbytes, 3'd0};
          pend_pad   <= (nbytes == 3'd4);
        end else begin
          bit_length <= bit_length + 64'd32;
        end
      end

      if (state == S_PAD) begin
        if (pend_pad) begin
          pend_pad <= 1'b0;
        end else if (len_lo_done) begin
          len_lo_done <= 1'b0;
        end else if (wc == 4'd14) begin
          len_lo_done <= 1'b1;
        end
      end

      if (state == S_COMP) begin
        step <= step + 7'd1;
        if (step == STEP_FOLD) begin
          chain.a <= chain.a + work.a;
          chain.b <= chain.b + work.b;
          chain.c <= chain.c + work.c;
          chain.d <= chain.d + work.d;
        end
      end

      if (dig_valid && dig_ready && !out_load) begin
        dig_valid <= 1'b0;
      end
      if (out_load) begin
        dig_valid <= 1'b1;
        out_idx   <= out_idx + 2'd1;
        if (out_idx == 2'd3) begin
          // last digest word loaded, start afresh for the next message
          chain      <= CHAIN_INIT;
          bit_length <= '0;
          wc         <= '0;
        end
      end
    end
  end

  // round datapath and output register
  always_ff @(posedge clk) begin
    if (state == S_COMP) begin
      if (step == 7'd0) begin
        work <= chain;
      end else if (step >= RND_FIRST && step <= RND_LAST) begin
        work <= work_rnd;
      end
      // constant plus message word, registered ahead of the round using it
      if (step >= KM_FIRST && step <= KM_LAST) begin
        km <= ROUND_K[kidx] + rd_data;
      end
    end
    if (out_load) begin
      dig_data.digest_word <= out_word;
      dig_data.word_index  <= out_idx;
      dig_data.last_result <= (out_idx == 2'd3);
    end
  end

  // the buffer is always empty when the digest is handed out
  a_out_empty_buf: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> wc == 4'd0)
    else $error("block buffer not empty while the digest is handed out");

  // digest words come out in order a, b, c, d
  a_dig_order: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !dig_data.last_result |=>
      !dig_valid || dig_data.word_index == $past(dig_data.word_index) + 2'd1)
    else $error("digest words out of order");

  // the pad word and the high length word are never owed together
  a_pad_len: assert property (@(posedge clk) disable iff (rst)
    state == S_PAD |-> !(pend_pad && len_lo_done))
    else $error("padding sequence broken");

endmodule

// ===== dv/tb_md5_digest_engine.sv =====
module tb_md5_digest_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  // ---------------------------------------------------------------------------
  // digest prediction and checking
  // ---------------------------------------------------------------------------

  // keeps its own copy of the message state, works out the four digest words
  // that every closing word must produce and holds them until they come out
  class md5_digest_tracker;
    logic [31:0] blk [16];
    int unsigned fill;
    logic [63:0] msg_bits;
    md5_abcd_t   chain;
    md5_out_t    digests_due [$];
    int unsigned mismatches;

    function new();
      foreach (blk[i]) blk[i] = '0;
      fill       = 0;
      msg_bits   = '0;
      chain      = CHAIN_INIT;
      mismatches = 0;
    endfunction

    function logic [31:0] rotate_left(input logic [31:0] x, input int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    // one full 64-round pass over the buffered block
    function void compress_block();
      logic [31:0] a, b, c, d, f, mixed;
      int unsigned g, q;
      a = chain.a;
      b = chain.b;
      c = chain.c;
      d = chain.d;
      for (int unsigned r = 0; r < 64; r++) begin
        q = r / 16;
        case (q)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        mixed = f + a + ROUND_K[r] + blk[g];
        a = d;
        d = c;
        c = b;
        b = b + rotate_left(mixed, int'(ROT_S[q * 4 + r % 4]));
      end
      chain.a += a;
      chain.b += b;
      chain.c += c;
      chain.d += d;
    endfunction

    function void append_word(input logic [31:0] w);
      blk[fill] = w;
      fill = (fill + 1) % 16;
      if (fill == 0) compress_block();
    endfunction

    // accepted message word: absorb it and, on the closing word, pad,
    // finish the digest and queue the four words it yields
    function void absorb_word(input md5_in_t w);
      int unsigned nbytes;
      logic [31:0] keep_mask;
      md5_out_t    dw;
      if (!w.last_word) begin
        msg_bits += 64'd32;
        append_word(w.data_word);
        return;
      end
      nbytes = (w.bytes_valid > 3'd4) ? 4 : w.bytes_valid;
      msg_bits += 64'(8 * nbytes);
      if (nbytes < 4) begin
        keep_mask = (nbytes == 0) ? 32'h0 : (32'hffff_ffff >> (32 - 8 * nbytes));
        append_word((w.data_word & keep_mask) | (32'(PAD_BYTE) << (8 * nbytes)));
      end else begin
        append_word(w.data_word);
        append_word(32'(PAD_BYTE));
      end
      // no room left for the length: fill up and start another block
      if (fill == 15) append_word('0);
      while (fill < 14) append_word('0);
      append_word(msg_bits[31:0]);
      append_word(msg_bits[63:32]);
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: dw.digest_word = chain.a;
          1: dw.digest_word = chain.b;
          2: dw.digest_word = chain.c;
          default: dw.digest_word = chain.d;
        endcase
        dw.word_index  = 2'(k);
        dw.last_result = (k == 3);
        digests_due.push_back(dw);
      end
      chain    = CHAIN_INIT;
      msg_bits = '0;
      fill     = 0;
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns mismatch, %s: got %h, want %h", $time, what, got, want);
      mismatches++;
    endtask

    // accepted digest transaction: compare against the oldest prediction
    task check_digest(input md5_out_t got);
      md5_out_t want;
      if (digests_due.size() == 0) begin
        report_mismatch("digest word with none outstanding", got.digest_word, '0);
        return;
      end
      want = digests_due.pop_front();
      if (got.digest_word !== want.digest_word)
        report_mismatch("digest_word", got.digest_word, want.digest_word);
      if (got.word_index !== want.word_index)
        report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and the block itself
  // ---------------------------------------------------------------------------

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     msg_valid = 1'b0;
  logic     msg_ready;
  md5_in_t  msg_data = '0;
  logic     dig_valid;
  logic     dig_ready = 1'b0;
  md5_out_t dig_data;

  md5_digest_tracker tracker;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  md5_digest_engine dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_data  (msg_data),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig_data  (dig_data)
  );

  // ---------------------------------------------------------------------------
  // monitors: every transaction is seen at the rising edge that completes it
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && msg_valid && msg_ready) tracker.absorb_word(msg_data);
  end

  always @(posedge clk) begin
    if (!rst && dig_valid && dig_ready) tracker.check_digest(dig_data);
  end

  // ---------------------------------------------------------------------------
  // digest receiver: changes ready at the falling edge, cycling through
  // stall modes of its own, plus one long hold-off that backs the engine up
  // ---------------------------------------------------------------------------

  bit          long_hold_go    = 1'b0;
  bit          long_hold_taken = 1'b0;
  int unsigned hold_left       = 0;
  int unsigned ready_mode      = 0;
  int unsigned mode_left       = 0;

  always @(negedge clk) begin
    if (rst) begin
      dig_ready <= 1'b0;
    end else begin
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = 600;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        dig_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       dig_ready <= 1'b1;                        // never stalls
          1:       dig_ready <= 1'($urandom_range(0, 1));    // coin toss
          2:       dig_ready <= ($urandom_range(0, 5) == 0); // mostly stalled
          default: dig_ready <= ($urandom_range(0, 7) != 0); // rare stalls
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // message sender: bursts of words with random gaps in between
  // ---------------------------------------------------------------------------

  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  bit          closing    = 1'b0;

  // called at a falling edge; returns at a falling edge after acceptance,
  // where valid either stays up for the next word or drops for a gap
  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic last);
    int unsigned gap;
    msg_data.data_word   <= data;
    msg_data.bytes_valid <= nbytes;
    msg_data.last_word   <= last;
    msg_valid            <= 1'b1;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
    if (burst_left == 0 || (closing && last)) begin
      msg_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // body words carry random data and a random (ignored) byte count
  task automatic send_message(input int unsigned body_words, input logic [2:0] tail_bytes);
    for (int unsigned i = 0; i < body_words; i++)
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, tail_bytes, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned body_words;
    int unsigned random_target;

    tracker = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, ignored data bits all set
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    // three bytes "abc"
    send_word(32'h0063_6261, 3'd3, 1'b1);
    // one full word, pad byte goes to a word of its own
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    // one and two bytes, the rest of the word must be dropped
    send_word(32'h1234_5678, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b1);
    // counts above four saturate to a full word
    send_word(32'hffff_ffff, 3'd5, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd6, 1'b1);
    send_word(32'h5a5a_5a5a, 3'd7, 1'b1);
    // byte count on a non-closing word is ignored
    send_word(32'h0000_0000, 3'd7, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    // fourteen words: the length no longer fits, so a second block follows
    for (int i = 0; i < 13; i++)
      send_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'(i % 8), 1'b0);
    send_word(32'hdead_beef, 3'd4, 1'b1);

    // random: mostly short messages, some that cross the block boundary;
    // the long hold-off starts here so the engine backs up behind it
    long_hold_go  = 1'b1;
    random_target = words_sent + 100;
    while (words_sent < random_target) begin
      body_words = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : $urandom_range(10, 17);
      closing    = (words_sent + body_words + 1 >= random_target);
      send_message(body_words, 3'($urandom_range(0, 7)));
    end

    // drain: wait for every predicted digest word, then a quiet spell
    while (tracker.digests_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS md5_digest_engine");
    end else begin
      $display("FAIL md5_digest_engine");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #2_000_000;
    $display("FAIL md5_digest_engine");
    $finish;
  end

endmodule
